/* hdl/hvp_pkg.sv */
// Package of the homogeneous vertex projection block: transaction types,
// pipeline depths and reset values of the matrix rows. No dependencies.
`default_nettype none

package hvp_pkg;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] vw;
  } vtx_in_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] pw;
    logic               w_was_zero;
  } vtx_out_t;

  localparam int unsigned DotStages  = 3;
  localparam int unsigned DivSteps   = 32;
  localparam int unsigned DivStages  = DivSteps + 2;
  localparam int unsigned PipeStages = DotStages + DivStages;

  localparam logic [1:0] RegRow0 = 2'd0;
  localparam logic [1:0] RegRow1 = 2'd1;
  localparam logic [1:0] RegRow2 = 2'd2;
  localparam logic [1:0] RegRow3 = 2'd3;

  localparam logic [63:0] Row0Reset = 64'h0000_0000_0000_1000;
  localparam logic [63:0] Row1Reset = 64'h0000_0000_1000_0000;
  localparam logic [63:0] Row2Reset = 64'h0000_1000_0000_0000;
  localparam logic [63:0] Row3Reset = 64'h1000_0000_0000_0000;

  localparam logic signed [31:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

endpackage

`default_nettype wire

/* hdl/hvp_dot.sv */
// Three-stage dot product of one matrix row with the vertex, rounded and
// saturated to Q16.16. Depends on hvp_pkg.
`default_nettype none

module hvp_dot (
  input  wire logic                          clk_i,
  input  wire logic [hvp_pkg::DotStages-1:0] en_i,
  input  wire logic [63:0]                   row_i,
  input  wire hvp_pkg::vtx_in_t              vec_i,
  output logic signed [31:0]                 t_o
);
  import hvp_pkg::*;

  logic signed [31:0] vec [4];
  logic signed [47:0] prod_d [4];
  logic signed [47:0] prod_q [4];
  logic signed [49:0] sum_d, sum_q;
  logic signed [37:0] shr;
  logic signed [31:0] t_d, t_q;

  always_comb begin
    vec[0] = vec_i.vx;
    vec[1] = vec_i.vy;
    vec[2] = vec_i.vz;
    vec[3] = vec_i.vw;
    for (int j = 0; j < 4; j++) begin
      prod_d[j] = $signed(row_i[16*j +: 16]) * vec[j];
    end
  end

  // Half is added before the floor shift, so ties go toward plus infinity.
  assign sum_d = prod_q[0] + prod_q[1] + prod_q[2] + prod_q[3] + 50'sd2048;
  assign shr   = 38'(sum_q >>> 12);

  always_comb begin
    if (shr > 38'(QMax)) begin
      t_d = QMax;
    end else if (shr < 38'(QMin)) begin
      t_d = QMin;
    end else begin
      t_d = shr[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
    end
    if (en_i[1]) begin
      sum_q <= sum_d;
    end
    if (en_i[2]) begin
      t_q <= t_d;
    end
  end

  assign t_o = t_q;

endmodule

`default_nettype wire

/* hdl/hvp_div.sv */
// Pipelined Q16.16 divider lane, one quotient bit per stage, truncating
// toward zero and saturating; a zero divisor passes the numerator. Uses hvp_pkg.
`default_nettype none

module hvp_div (
  input  wire logic                          clk_i,
  input  wire logic [hvp_pkg::DivStages-1:0] en_i,
  input  wire logic signed [31:0]            num_i,
  input  wire logic signed [31:0]            den_i,
  output logic signed [31:0]                 q_o
);
  import hvp_pkg::*;

  logic [31:0] anum, aden;
  logic        ovf_d;

  logic [31:0]        rem_q  [DivSteps+1];
  logic [31:0]        lo_q   [DivSteps+1];
  logic [31:0]        den_q  [DivSteps+1];
  logic               neg_q  [DivSteps+1];
  logic               ovf_q  [DivSteps+1];
  logic               zero_q [DivSteps+1];
  logic signed [31:0] pass_q [DivSteps+1];

  logic [32:0] trial  [DivSteps+1];
  logic        ge     [DivSteps+1];
  logic [32:0] diff   [DivSteps+1];

  logic signed [31:0] q_d, q_q;
  logic [31:0]        quo;

  assign anum = num_i[31] ? (~num_i + 32'd1) : num_i;
  assign aden = den_i[31] ? (~den_i + 32'd1) : den_i;
  // The quotient reaches 2^32 exactly when the upper numerator part reaches the divisor.
  assign ovf_d = {16'd0, anum[31:16]} >= aden;

  always_comb begin
    trial[0] = '0;
    ge[0]    = 1'b0;
    diff[0]  = '0;
    for (int s = 1; s <= DivSteps; s++) begin
      trial[s] = {rem_q[s-1], lo_q[s-1][31]};
      ge[s]    = trial[s] >= {1'b0, den_q[s-1]};
      diff[s]  = trial[s] - {1'b0, den_q[s-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]  <= {16'd0, anum[31:16]};
      lo_q[0]   <= {anum[15:0], 16'd0};
      den_q[0]  <= aden;
      neg_q[0]  <= num_i[31] ^ den_i[31];
      ovf_q[0]  <= ovf_d;
      zero_q[0] <= (den_i == 32'sd0);
      pass_q[0] <= num_i;
    end
    for (int s = 1; s <= DivSteps; s++) begin
      if (en_i[s]) begin
        rem_q[s]  <= ge[s] ? diff[s][31:0] : trial[s][31:0];
        lo_q[s]   <= {lo_q[s-1][30:0], ge[s]};
        den_q[s]  <= den_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
        zero_q[s] <= zero_q[s-1];
        pass_q[s] <= pass_q[s-1];
      end
    end
    if (en_i[DivStages-1]) begin
      q_q <= q_d;
    end
  end

  assign quo = lo_q[DivSteps];

  always_comb begin
    if (zero_q[DivSteps]) begin
      q_d = pass_q[DivSteps];
    end else if (ovf_q[DivSteps]) begin
      q_d = neg_q[DivSteps] ? QMin : QMax;
    end else if (neg_q[DivSteps]) begin
      q_d = (quo > 32'h8000_0000) ? QMin : $signed(~quo + 32'd1);
    end else begin
      q_d = quo[31] ? QMax : $signed(quo);
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

/* hdl/homogeneous_vertex_projection.sv */
// Top level of the homogeneous vertex projection block. Instantiates four
// hvp_dot row units and three hvp_div lanes; uses hvp_pkg.
//
// The block multiplies each Q16.16 vertex by the 4x4 Q4.12 matrix held in
// four row registers and divides x, y and z by the transformed w. It
// accepts one vertex transaction per clock unless it refuses input as
// described below, and returns one result transaction per vertex, in
// order, after the row dot products (multiply, sum, round and saturate),
// divider setup, the one-bit-per-stage quotient pipeline and sign fixup
// and saturation. Every stage holds its own valid bit; a stage loads
// whenever it is empty or the stage after it moves, so bubbles close up
// and an input transaction is refused only when all stages are full and
// the output is stalled. Matrix rows may be rewritten only while no
// transaction is in flight.
`default_nettype none

module homogeneous_vertex_projection (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [63:0]      cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire hvp_pkg::vtx_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output hvp_pkg::vtx_out_t     out_data_o
);
  import hvp_pkg::*;

  logic [63:0] row_q [4];

  // Stage k loads on en[k]; en[PipeStages] is the downstream side.
  logic [PipeStages:0]   en;
  logic [PipeStages-1:0] valid_q;

  logic signed [31:0] t [4];
  logic signed [31:0] q [3];

  logic signed [31:0] pw_q [DivStages];
  logic               wz_q [DivStages];

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= Row0Reset;
      row_q[1] <= Row1Reset;
      row_q[2] <= Row2Reset;
      row_q[3] <= Row3Reset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRow0: row_q[0] <= cfg_wdata_i;
        RegRow1: row_q[1] <= cfg_wdata_i;
        RegRow2: row_q[2] <= cfg_wdata_i;
        RegRow3: row_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when it is empty or its successor moves.
  always_comb begin
    en[PipeStages] = !out_stall_i;
    for (int k = PipeStages - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < PipeStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_stall_o = !en[0];

  for (genvar r = 0; r < 4; r++) begin : g_row
    hvp_dot u_dot (
      .clk_i (clk_i),
      .en_i  (en[DotStages-1:0]),
      .row_i (row_q[r]),
      .vec_i (in_data_i),
      .t_o   (t[r])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    hvp_div u_div (
      .clk_i (clk_i),
      .en_i  (en[PipeStages-1:DotStages]),
      .num_i (t[c]),
      .den_i (t[3]),
      .q_o   (q[c])
    );
  end

  // The transformed w and its zero flag ride alongside the divider lanes.
  always_ff @(posedge clk_i) begin
    if (en[DotStages]) begin
      pw_q[0] <= t[3];
      wz_q[0] <= (t[3] == 32'sd0);
    end
    for (int k = 1; k < DivStages; k++) begin
      if (en[DotStages+k]) begin
        pw_q[k] <= pw_q[k-1];
        wz_q[k] <= wz_q[k-1];
      end
    end
  end

  assign out_valid_o           = valid_q[PipeStages-1];
  assign out_data_o.px         = q[0];
  assign out_data_o.py         = q[1];
  assign out_data_o.pz         = q[2];
  assign out_data_o.pw         = pw_q[DivStages-1];
  assign out_data_o.w_was_zero = wz_q[DivStages-1];

  // The zero flag must match the w that travels with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.w_was_zero == (out_data_o.pw == 32'sd0)))
    else $error("w_was_zero disagrees with pw");

  // Input is refused only when every stage is full and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&valid_q) && out_stall_i))
    else $error("input stalled while the pipeline has room");

  // A stalled output transaction stays valid and keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output transaction changed");

endmodule

`default_nettype wire
